// ===== design/dkc_pkg.sv =====
// dkc_pkg: shared constants and register codes for the dipole kernel coefficient block.
// No dependencies; compiled first.

package dkc_pkg;

    // spacing squared registers are unsigned Q8.8
    localparam int SP_BITS = 16;

    // configuration port geometry
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_X_LAST       = 3'd0,
        CFG_Y_LAST       = 3'd1,
        CFG_Z_LAST       = 3'd2,
        CFG_X_SPACING_SQ = 3'd3,
        CFG_Y_SPACING_SQ = 3'd4,
        CFG_Z_SPACING_SQ = 3'd5,
        CFG_CLAMP_MODE   = 3'd6
    } cfg_reg_t;

    localparam logic [SP_BITS-1:0] SP_RESET = 16'd256;

endpackage

// ===== design/dkc_in_if.sv =====
// dkc_in_if: valid/ready channel carrying one voxel coordinate.
// Depends on nothing; width set by INDEX_BITS.

interface dkc_in_if #(
    parameter int INDEX_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] x_index;
    logic [INDEX_BITS-1:0] y_index;
    logic [INDEX_BITS-1:0] z_index;

    modport source (output valid, output x_index, output y_index, output z_index,
                    input ready);
    modport sink   (input valid, input x_index, input y_index, input z_index,
                    output ready);
endinterface

// ===== design/dkc_out_if.sv =====
// dkc_out_if: valid/ready channel carrying one dipole coefficient.
// Depends on nothing; width set by COEF_BITS.

interface dkc_out_if #(
    parameter int COEF_BITS = 17
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

// ===== design/dkc_axis.sv =====
// dkc_axis: one axis lane, three registered steps: fold the index, square it,
// scale by the spacing squared. Depends on no package items.

module dkc_axis #(
    parameter int IW  = 8,
    parameter int SPW = 16
) (
    input  logic                   clk,
    input  logic                   en_fold,
    input  logic                   en_square,
    input  logic                   en_scale,
    input  logic [IW-1:0]          idx,
    input  logic [IW-1:0]          last,
    input  logic [SPW-1:0]         sp,
    output logic [2*IW+SPW-1:0]    k
);
    localparam int SQW = 2 * IW;
    localparam int KW  = SQW + SPW;

    logic [IW-1:0]  d_reg;
    logic [IW-1:0]  d_next;
    logic [SQW-1:0] sq_reg;
    logic [KW-1:0]  k_reg;

    // fold about the grid center; past the last index use the distance to it
    always_comb
    begin
        if ({idx, 1'b0} < {1'b0, last})
            d_next = idx;
        else if (last >= idx)
            d_next = last - idx;
        else
            d_next = idx - last;
    end

    always_ff @(posedge clk)
    begin
        if (en_fold)
            d_reg <= d_next;
        if (en_square)
            sq_reg <= {{IW{1'b0}}, d_reg} * {{IW{1'b0}}, d_reg};
        if (en_scale)
            k_reg <= {{SPW{1'b0}}, sq_reg} * {{SQW{1'b0}}, sp};
    end

    assign k = k_reg;
endmodule

// ===== design/dkc_div_cell.sv =====
// dkc_div_cell: one restoring-division cell; develops one quotient bit per
// transfer and hands remainder, divisor and partial quotient to the next cell.

module dkc_div_cell #(
    parameter int DW    = 34,
    parameter int QW    = 17,
    parameter bit FIRST = 1'b0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] r_in,
    input  logic [DW-1:0] den_in,
    input  logic [QW-1:0] q_in,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] r_out,
    output logic [DW-1:0] den_out,
    output logic [QW-1:0] q_out
);
    logic          valid_reg;
    logic          adv;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] r_next;
    logic [QW-1:0] q_next;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] q_reg;

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // first cell compares the numerator as is; later cells double the remainder
    always_comb
    begin
        t      = (FIRST != 1'b0) ? {1'b0, r_in} : {r_in, 1'b0};
        diff   = t - {1'b0, den_in};
        ge     = (t >= {1'b0, den_in});
        r_next = ge ? diff[DW-1:0] : t[DW-1:0];
        q_next = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg   <= r_next;
            den_reg <= den_in;
            q_reg   <= q_next;
        end
    end

    assign out_valid = valid_reg;
    assign r_out     = r_reg;
    assign den_out   = den_reg;
    assign q_out     = q_reg;
endmodule

// ===== design/dipole_kernel_coefficient_top.sv =====
// Dipole kernel coefficient generator, top level.
// Depends on dkc_pkg, dkc_in_if, dkc_out_if, dkc_axis and dkc_div_cell.

// Takes a voxel index triple per cycle while voxel.ready is high and returns
// 1/3 - kz2/(kx2+ky2+kz2) as signed Q1.FRAC_BITS (0 for a zero denominator;
// clamp mode sets near-zero results to epsilon). Stages: three lane stages
// (fold, square, scale), one summing stage, a chain of FRAC_BITS+1 division
// cells that each settle one quotient bit, and the output register. Every
// stage holds its own valid bit, so bubbles close up and new voxels keep
// entering while a result waits at the output. Configuration is taken from
// the live registers, so write it only while no voxel is in flight.

module dipole_kernel_coefficient_top #(
    parameter int INDEX_BITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dkc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dkc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    dkc_in_if.sink                            voxel,
    dkc_out_if.source                         result
);
    localparam int IW  = INDEX_BITS;
    localparam int SPW = dkc_pkg::SP_BITS;
    localparam int KW  = 2 * IW + SPW;
    localparam int DW  = KW + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NC  = FRAC_BITS + 1;
    localparam int CW  = FRAC_BITS + 1;
    localparam int VW  = FRAC_BITS + 2;

    localparam int THIRD_I = (2 ** FRAC_BITS) / 3;
    localparam int EPS_I   = (2 ** FRAC_BITS) / 100;
    localparam logic signed [VW-1:0] THIRD_V   = VW'(THIRD_I);
    localparam logic signed [VW-1:0] EPS_V     = VW'(EPS_I);
    localparam logic signed [VW-1:0] NEG_EPS_V = -VW'(EPS_I);
    localparam logic signed [CW-1:0] MIN_C     = CW'(THIRD_I - 2 ** FRAC_BITS);
    localparam logic signed [CW-1:0] MAX_C     = CW'(THIRD_I);

    // configuration registers
    logic [IW-1:0]  x_last_reg;
    logic [IW-1:0]  y_last_reg;
    logic [IW-1:0]  z_last_reg;
    logic [SPW-1:0] x_sp_reg;
    logic [SPW-1:0] y_sp_reg;
    logic [SPW-1:0] z_sp_reg;
    logic           clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_last_reg <= IW'(255);
            y_last_reg <= IW'(255);
            z_last_reg <= IW'(255);
            x_sp_reg   <= dkc_pkg::SP_RESET;
            y_sp_reg   <= dkc_pkg::SP_RESET;
            z_sp_reg   <= dkc_pkg::SP_RESET;
            clamp_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (dkc_pkg::cfg_reg_t'(cfg_index))
                dkc_pkg::CFG_X_LAST:       x_last_reg <= cfg_data[IW-1:0];
                dkc_pkg::CFG_Y_LAST:       y_last_reg <= cfg_data[IW-1:0];
                dkc_pkg::CFG_Z_LAST:       z_last_reg <= cfg_data[IW-1:0];
                dkc_pkg::CFG_X_SPACING_SQ: x_sp_reg   <= cfg_data[SPW-1:0];
                dkc_pkg::CFG_Y_SPACING_SQ: y_sp_reg   <= cfg_data[SPW-1:0];
                dkc_pkg::CFG_Z_SPACING_SQ: z_sp_reg   <= cfg_data[SPW-1:0];
                dkc_pkg::CFG_CLAMP_MODE:   clamp_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front stages: fold, square, scale, sum
    logic [3:0] vld_reg;
    logic [3:0] adv;
    logic [NC:0] cv;
    logic [NC:0] crdy;

    always_comb
    begin
        adv[3] = !vld_reg[3] || crdy[0];
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign voxel.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= voxel.valid;
            if (adv[1])
                vld_reg[1] <= vld_reg[0];
            if (adv[2])
                vld_reg[2] <= vld_reg[1];
            if (adv[3])
                vld_reg[3] <= vld_reg[2];
        end
    end

    logic [KW-1:0] kx;
    logic [KW-1:0] ky;
    logic [KW-1:0] kz;

    dkc_axis #(.IW(IW), .SPW(SPW)) u_axis_x (
        .clk(clk), .en_fold(adv[0]), .en_square(adv[1]), .en_scale(adv[2]),
        .idx(voxel.x_index), .last(x_last_reg), .sp(x_sp_reg), .k(kx)
    );
    dkc_axis #(.IW(IW), .SPW(SPW)) u_axis_y (
        .clk(clk), .en_fold(adv[0]), .en_square(adv[1]), .en_scale(adv[2]),
        .idx(voxel.y_index), .last(y_last_reg), .sp(y_sp_reg), .k(ky)
    );
    dkc_axis #(.IW(IW), .SPW(SPW)) u_axis_z (
        .clk(clk), .en_fold(adv[0]), .en_square(adv[1]), .en_scale(adv[2]),
        .idx(voxel.z_index), .last(z_last_reg), .sp(z_sp_reg), .k(kz)
    );

    logic [DW-1:0] den_reg;
    logic [DW-1:0] kz_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            den_reg <= {2'b00, kx} + {2'b00, ky} + {2'b00, kz};
            kz_reg  <= {2'b00, kz};
        end
    end

    // division chain, one quotient bit per cell
    logic [DW-1:0] cr   [0:NC];
    logic [DW-1:0] cden [0:NC];
    logic [QW-1:0] cq   [0:NC];

    assign cv[0]   = vld_reg[3];
    assign cr[0]   = kz_reg;
    assign cden[0] = den_reg;
    assign cq[0]   = '0;

    for (genvar c = 0; c < NC; c++)
    begin : g_div
        dkc_div_cell #(.DW(DW), .QW(QW), .FIRST(c == 0)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (cv[c]),
            .in_ready (crdy[c]),
            .r_in     (cr[c]),
            .den_in   (cden[c]),
            .q_in     (cq[c]),
            .out_valid(cv[c+1]),
            .out_ready(crdy[c+1]),
            .r_out    (cr[c+1]),
            .den_out  (cden[c+1]),
            .q_out    (cq[c+1])
        );
    end

    // output stage: subtract from one third, zero-denominator case, clamp
    logic                 out_valid_reg;
    logic [CW-1:0]        coef_reg;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] v_final;

    assign crdy[NC] = !out_valid_reg || result.ready;

    always_comb
    begin
        if (cden[NC] == '0)
            v = '0;
        else
            v = THIRD_V - $signed({1'b0, cq[NC]});
        if (clamp_reg && (v >= NEG_EPS_V) && (v <= EPS_V))
            v_final = EPS_V;
        else
            v_final = v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (crdy[NC])
            out_valid_reg <= cv[NC];
    end

    always_ff @(posedge clk)
    begin
        if (crdy[NC])
            coef_reg <= v_final[CW-1:0];
    end

    assign result.valid       = out_valid_reg;
    assign result.coefficient = coef_reg;

    // input stalls only when every stage holds an item and the output is blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !voxel.ready |-> (&vld_reg) && (&cv[NC:1]) && out_valid_reg && !result.ready)
        else $error("input stalled while the pipeline has a free stage");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        voxel.valid && voxel.ready |=> vld_reg[0])
        else $error("accepted voxel did not enter the fold stage");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.coefficient) >= MIN_C)
                      && ($signed(result.coefficient) <= MAX_C))
        else $error("coefficient outside the range of the kernel");

endmodule

// ===== tb/testbench.sv =====
// Testbench for dipole_kernel_coefficient_top: random and directed voxels under several
// register settings, each coefficient predicted in a scoreboard class and checked in order.
// Depends on dkc_pkg, dkc_in_if, dkc_out_if and the block's RTL.

module testbench;
    localparam int             COEF_BITS        = 17;
    localparam longint         THIRD_Q16        = 65536 / 3;
    localparam longint         CLAMP_EPS_Q16    = 65536 / 100;
    localparam logic [2:0]     CFG_UNUSED_INDEX = 3'd7;
    // pipeline depth is 22 at the defaults; give it some margin
    localparam int             FLUSH_CYCLES     = 32;

    // Holds the register image and the coefficients still owed by the block.
    class coef_board;
        logic [7:0]                  x_last, y_last, z_last;
        logic [15:0]                 x_sp, y_sp, z_sp;
        logic                        clamp;
        logic signed [COEF_BITS-1:0] pending[$];
        int                          errors;
        int                          noted;
        int                          checked;
        int                          clamped;
        int                          zero_den;

        function new();
            x_last = 8'd255;
            y_last = 8'd255;
            z_last = 8'd255;
            x_sp   = dkc_pkg::SP_RESET;
            y_sp   = dkc_pkg::SP_RESET;
            z_sp   = dkc_pkg::SP_RESET;
            clamp  = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                dkc_pkg::CFG_X_LAST:       x_last = data[7:0];
                dkc_pkg::CFG_Y_LAST:       y_last = data[7:0];
                dkc_pkg::CFG_Z_LAST:       z_last = data[7:0];
                dkc_pkg::CFG_X_SPACING_SQ: x_sp   = data;
                dkc_pkg::CFG_Y_SPACING_SQ: y_sp   = data;
                dkc_pkg::CFG_Z_SPACING_SQ: z_sp   = data;
                dkc_pkg::CFG_CLAMP_MODE:   clamp  = data[0];
                default:                   ;
            endcase
        endfunction

        // squared distance from the nearer grid edge, scaled by spacing squared
        function longint fold_scaled(logic [7:0] idx, logic [7:0] last_idx,
                                     logic [15:0] spacing_sq);
            longint d;
            if (2 * longint'(idx) < longint'(last_idx))
                d = longint'(idx);
            else if (last_idx >= idx)
                d = longint'(last_idx) - longint'(idx);
            else
                d = longint'(idx) - longint'(last_idx);
            return d * d * longint'(spacing_sq);
        endfunction

        function logic signed [COEF_BITS-1:0] coefficient_of(logic [7:0] x, logic [7:0] y,
                                                             logic [7:0] z);
            longint kx, ky, kz, den, v;
            kx  = fold_scaled(x, x_last, x_sp);
            ky  = fold_scaled(y, y_last, y_sp);
            kz  = fold_scaled(z, z_last, z_sp);
            den = kx + ky + kz;
            if (den == 0)
            begin
                v = 0;
                zero_den++;
            end
            else
                v = THIRD_Q16 - (kz * 65536) / den;
            if (clamp && v >= -CLAMP_EPS_Q16 && v <= CLAMP_EPS_Q16)
            begin
                v = CLAMP_EPS_Q16;
                clamped++;
            end
            return v[COEF_BITS-1:0];
        endfunction

        function void note_voxel(logic [7:0] x, logic [7:0] y, logic [7:0] z);
            pending.push_back(coefficient_of(x, y, z));
            noted++;
        endfunction

        function void check_coefficient(logic signed [COEF_BITS-1:0] got);
            logic signed [COEF_BITS-1:0] want;
            if (pending.size() == 0)
            begin
                $error("coefficient %0d arrived with no voxel outstanding", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("coefficient mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [dkc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [dkc_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    dkc_in_if  #(.INDEX_BITS(8))        voxel_ch ();
    dkc_out_if #(.COEF_BITS(COEF_BITS)) coef_ch ();

    coef_board board = new();
    int        tx_style;
    int        rx_style;
    int        settings;

    dipole_kernel_coefficient_top #(
        .INDEX_BITS(8),
        .FRAC_BITS (16)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .voxel    (voxel_ch),
        .result   (coef_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // 0: full range of waits, 1: no waits, 2: short waits with a rare long one
    function automatic int draw_wait(int style);
        case (style)
            0:       return $urandom_range(0, 18);
            1:       return 0;
            default: return ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(0, 2);
        endcase
    endfunction

    task automatic send_voxel(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z);
        int gap;
        gap = draw_wait(tx_style);
        if (gap > 0)
        begin
            voxel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        voxel_ch.valid   <= 1'b1;
        voxel_ch.x_index <= x;
        voxel_ch.y_index <= y;
        voxel_ch.z_index <= z;
        @(posedge clk);
        while (!voxel_ch.ready)
            @(posedge clk);
        board.note_voxel(x, y, z);
    endtask

    // Drop valid and hold until every owed coefficient is back and the pipe is empty.
    task automatic settle();
        voxel_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending.size() != 0);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Unused upper data bits carry junk; the block must ignore them.
    task automatic load_config(input logic [7:0] xl, input logic [7:0] yl, input logic [7:0] zl,
                               input logic [15:0] xs, input logic [15:0] ys,
                               input logic [15:0] zs, input logic cm);
        write_reg(dkc_pkg::CFG_X_LAST, {8'($urandom_range(0, 255)), xl});
        write_reg(dkc_pkg::CFG_Y_LAST, {8'($urandom_range(0, 255)), yl});
        write_reg(dkc_pkg::CFG_Z_LAST, {8'($urandom_range(0, 255)), zl});
        write_reg(dkc_pkg::CFG_X_SPACING_SQ, xs);
        write_reg(dkc_pkg::CFG_Y_SPACING_SQ, ys);
        write_reg(dkc_pkg::CFG_Z_SPACING_SQ, zs);
        write_reg(dkc_pkg::CFG_CLAMP_MODE, {15'($urandom_range(0, 32767)), cm});
        write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(0, 65535)));
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [7:0] pick_last();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(1, 16));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_spacing();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 512));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // index near the fold point or the top of an axis
    function automatic logic [7:0] near_fold(logic [7:0] last_idx);
        int base;
        base = ($urandom_range(0, 1) == 0) ? (last_idx >> 1) : last_idx;
        base = base + $urandom_range(0, 2) - 1;
        if (base < 0)
            base = 0;
        return 8'(base);
    endfunction

    task automatic send_random_voxel();
        logic [7:0] x, y, z;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                x = 8'($urandom_range(0, 255));
                y = 8'($urandom_range(0, 255));
                z = 8'($urandom_range(0, 255));
            end
            2:
            begin
                x = near_fold(board.x_last);
                y = near_fold(board.y_last);
                z = near_fold(board.z_last);
            end
            3:
            begin
                // equal indices give a near-zero coefficient under equal axis settings
                x = 8'($urandom_range(0, 255));
                y = x;
                z = x;
            end
            default:
            begin
                x = 8'($urandom_range(0, 3));
                y = 8'($urandom_range(0, 3));
                z = 8'($urandom_range(0, 3));
            end
        endcase
        send_voxel(x, y, z);
    endtask

    task automatic run_receiver();
        int stall;
        int taken;
        taken = 0;
        forever
        begin
            stall = draw_wait(rx_style);
            if (stall > 0)
            begin
                coef_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            coef_ch.ready <= 1'b1;
            @(posedge clk);
            while (!coef_ch.valid)
                @(posedge clk);
            board.check_coefficient(coef_ch.coefficient);
            taken++;
            if (taken % 48 == 0)
                rx_style = $urandom_range(0, 2);
        end
    endtask

    initial
    begin
        coef_ch.ready = 1'b0;
        rx_style      = 0;
        @(posedge rst_n);
        @(posedge clk);
        run_receiver();
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = dkc_pkg::CFG_X_LAST;
        cfg_data         = '0;
        voxel_ch.valid   = 1'b0;
        voxel_ch.x_index = '0;
        voxel_ch.y_index = '0;
        voxel_ch.z_index = '0;
        tx_style         = 0;
        settings         = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero denominator, fold edges, pure kx, pure ky and pure kz
        send_voxel(8'd0, 8'd0, 8'd0);
        send_voxel(8'd255, 8'd255, 8'd255);
        send_voxel(8'd127, 8'd127, 8'd127);
        send_voxel(8'd128, 8'd128, 8'd128);
        send_voxel(8'd1, 8'd1, 8'd1);
        send_voxel(8'd0, 8'd0, 8'd1);
        send_voxel(8'd1, 8'd0, 8'd0);
        send_voxel(8'd0, 8'd1, 8'd0);
        send_voxel(8'd0, 8'd0, 8'd127);
        send_voxel(8'd0, 8'd0, 8'd128);
        send_voxel(8'd127, 8'd0, 8'd0);
        send_voxel(8'd1, 8'd1, 8'd0);
        send_voxel(8'd200, 8'd55, 8'd3);
        send_voxel(8'd254, 8'd254, 8'd254);
        send_voxel(8'd3, 8'd4, 8'd5);
        settle();

        // clamp on: zero coefficient and zero denominator both become epsilon
        load_config(8'd255, 8'd255, 8'd255, dkc_pkg::SP_RESET, dkc_pkg::SP_RESET,
                    dkc_pkg::SP_RESET, 1'b1);
        send_voxel(8'd0, 8'd0, 8'd0);
        send_voxel(8'd1, 8'd1, 8'd1);
        send_voxel(8'd2, 8'd2, 8'd2);
        send_voxel(8'd0, 8'd0, 8'd1);
        send_voxel(8'd1, 8'd0, 8'd0);
        send_voxel(8'd9, 8'd8, 8'd9);
        settle();

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:  load_config(8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                1:  load_config(8'd255, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0);
                2:  load_config(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
                3:  load_config(pick_last(), pick_last(), pick_last(), 16'd0, 16'd0,
                                pick_spacing(), 1'b1);
                default:
                    load_config(pick_last(), pick_last(), pick_last(), pick_spacing(),
                                pick_spacing(), pick_spacing(), 1'($urandom_range(0, 1)));
            endcase
            tx_style = phase % 3;
            for (int n = 0; n < 160; n++)
            begin
                // drain once mid-stream with the input held idle
                if (phase == 4 && n == 80)
                    settle();
                send_random_voxel();
            end
            settle();
        end

        $display("Checked %0d coefficients from %0d voxels across %0d register settings.",
                 board.checked, board.noted, settings);
        $display("Zero-denominator voxels: %0d, coefficients clamped to epsilon: %0d.",
                 board.zero_den, board.clamped);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
